// ----- sv/mrk_pkg.sv -----
package mrk_pkg;

  localparam int IN_W       = 16;
  localparam int WHEEL_W    = 18;
  localparam int RAMP_W     = 24;
  localparam int LEVER_W    = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // integer bits of floor(accel * dt / 1e6) for 16-bit accel and dt
  localparam int STEP_INT_W = 13;
  localparam int STEP_DEN   = 1000000;
  localparam int LEVER_DEN  = 1000;

  localparam int CORDIC_STEPS = 24;
  localparam int CORD_IW      = $clog2(CORDIC_STEPS);
  localparam int CORD_W       = 34;
  localparam int ATAN_W       = 30;
  localparam int CS_W         = 18;
  localparam int CS_FRAC      = 16;
  localparam int CORD_SHIFT   = 14;
  localparam int CORD_ROUND   = 1 << (CORD_SHIFT - 1);
  localparam int GAIN_FRAC    = 8;

  localparam logic signed [CORD_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [RAMP_W-1:0]  RAMP_MAX    = 24'sh7FFFFF;
  localparam logic signed [RAMP_W-1:0]  RAMP_MIN    = 24'sh800000;
  localparam logic signed [WHEEL_W-1:0] WHEEL_MAX   = 18'sh1FFFF;
  localparam logic signed [WHEEL_W-1:0] WHEEL_MIN   = 18'sh20000;

  localparam logic [15:0]        LIN_ACCEL_RST = 16'd4000;
  localparam logic [15:0]        ANG_ACCEL_RST = 16'd12000;
  localparam logic [LEVER_W-1:0] LEVER_RST     = 10'd300;
  localparam logic [15:0]        DASH_GAIN_RST = 16'd384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINEAR_ACCEL  = 4'd0,
    CFG_ANGULAR_ACCEL = 4'd1,
    CFG_LEVER_ARM     = 4'd2,
    CFG_DASH_GAIN     = 4'd3
  } cfg_idx_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [CORD_IW-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/mrk_ifs.sv -----
interface mrk_in_if import mrk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  target_vx;
  logic signed [IN_W-1:0]  target_vy;
  logic signed [IN_W-1:0]  target_wz;
  logic [IN_W-1:0]         yaw_error;
  logic [IN_W-1:0]         elapsed_us;
  logic                    mode;
  modport source (output valid, target_vx, target_vy, target_wz, yaw_error, elapsed_us,
                  mode, input ready);
  modport sink   (input valid, target_vx, target_vy, target_wz, yaw_error, elapsed_us,
                  mode, output ready);
endinterface

interface mrk_out_if import mrk_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WHEEL_W-1:0] wheel_front_left;
  logic signed [WHEEL_W-1:0] wheel_front_right;
  logic signed [WHEEL_W-1:0] wheel_rear_left;
  logic signed [WHEEL_W-1:0] wheel_rear_right;
  modport source (output valid, wheel_front_left, wheel_front_right, wheel_rear_left,
                  wheel_rear_right, input ready);
  modport sink   (input valid, wheel_front_left, wheel_front_right, wheel_rear_left,
                  wheel_rear_right, output ready);
endinterface

interface mrk_cfg_if import mrk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/mrk_smul.sv -----
module mrk_smul #(
  parameter int WA = 24,
  parameter int WB = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic                  busy,
  output logic signed [WA+WB-1:0] p
);
  localparam int PW = WA + WB;
  localparam int CW = $clog2(WB + 1);

  logic signed [PW-1:0] mc_r;
  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] addend;
  logic [WB-1:0]        mb_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 last;

  assign last = (cnt_r == CW'(1));

  // the multiplier's sign bit carries negative weight
  always_comb begin
    if (!mb_r[0]) addend = '0;
    else if (last) addend = -mc_r;
    else addend = mc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(WB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (last) busy_r <= 1'b0;
    end
    if (start) begin
      mc_r  <= PW'(a);
      mb_r  <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + addend;
      mc_r  <= mc_r <<< 1;
      mb_r  <= mb_r >> 1;
    end
  end

  assign busy = busy_r;
  assign p    = acc_r;

endmodule

// ----- sv/mrk_udiv.sv -----
module mrk_udiv #(
  parameter int WN  = 40,
  parameter int QW  = 21,
  parameter int DEN = 1000000
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WN-1:0] num,
  output logic          busy,
  output logic [QW-1:0] q
);
  localparam int WD  = $clog2(DEN + 1);
  localparam int WD1 = WD + 1;
  localparam int CW  = $clog2(QW + 1);
  localparam logic [WD:0] DEN_V = WD1'(DEN);

  logic [WD-1:0] rem_r;
  logic [QW-1:0] nb_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [WD:0]   trial;
  logic [WD:0]   diff;
  logic          ge;

  assign trial = {rem_r, nb_r[QW-1]};
  assign ge    = (trial >= DEN_V);
  assign diff  = trial - DEN_V;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
    if (start) begin
      // upper bits stay below the divisor, so only QW quotient bits remain
      rem_r <= WD'(num >> QW);
      nb_r  <= num[QW-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WD-1:0] : trial[WD-1:0];
      nb_r  <= nb_r << 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign q    = q_r;

endmodule

// ----- sv/mecanum_ramp_kinematics.sv -----
// Mecanum wheel inverse kinematics with slew-limited targets. Each input beat carries
// target vx, vy, wz in the turret frame, the turret yaw error (65536 per turn), the
// time since the last tick and a dash flag; it produces one output beat with four
// wheel setpoints in mm/s, saturated to 18 bits. Three ramped targets (24 bit, with
// RAMP_FRAC_BITS fraction bits) move toward the commands by accel * dt per tick.
// The block works on one beat at a time: it takes the next beat only after the result
// of the last one has been loaded into the output register, which waits until the previous
// result is taken. The time is set by the 24-iteration CORDIC, the bit-serial divide for
// the ramp step, the bit-serial multipliers and the lever-arm divide. A finished result
// sits in the output register while the next beat is accepted. Configuration writes are
// taken every cycle and must only be issued while the block is idle.
module mecanum_ramp_kinematics import mrk_pkg::*; #(
  parameter int RAMP_FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  mrk_cfg_if.sink   cfg_ch,
  mrk_in_if.sink    in_ch,
  mrk_out_if.source out_ch
);
  localparam int F       = RAMP_FRAC_BITS;
  localparam int MA_W    = RAMP_W;
  localparam int MB_W    = CS_W;
  localparam int P_W     = MA_W + MB_W;
  localparam int PD_W    = P_W + MB_W;
  localparam int PS_W    = P_W + 1;
  localparam int DS_W    = PD_W + 1;
  localparam int STEP_NW = 2 * IN_W + F;
  localparam int STEP_QW = STEP_INT_W + F;
  localparam int TGT_W   = IN_W + F;
  localparam int CMP_W   = ((TGT_W > RAMP_W) ? TGT_W : RAMP_W) + 2;
  localparam int RN_W    = RAMP_W + LEVER_W;
  localparam int R_W     = RAMP_W + 1;
  localparam int CX_W    = PS_W - CS_FRAC;
  localparam int CY_W    = DS_W - CS_FRAC - GAIN_FRAC;
  localparam int W_W     = CY_W + 2;
  localparam int HALF    = (1 << F) / 2;
  localparam logic [CORD_IW-1:0] CORD_LAST = CORD_IW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_STEP, ST_RAMP, ST_PROD, ST_PROD_WAIT, ST_TAIL, ST_SUM, ST_OUT
  } st_t;

  st_t state_r;

  logic [15:0]         lin_accel_r, ang_accel_r, dash_gain_r;
  logic [LEVER_W-1:0]  lever_r;
  logic signed [RAMP_W-1:0] ramp_vx_r, ramp_vy_r, ramp_wz_r;
  logic signed [IN_W-1:0]   tgt_vx_r, tgt_vy_r, tgt_wz_r;
  logic                mode_r;

  logic signed [CORD_W-1:0] cord_x_r, cord_y_r, cord_z_r;
  logic [CORD_IW-1:0]  cord_i_r;
  logic                cord_busy_r;
  logic                flip_r;
  logic signed [CS_W-1:0] cos_r, sin_r;

  logic signed [CX_W-1:0] cx_r;
  logic signed [CY_W-1:0] cy_r;
  logic signed [R_W-1:0]  rot_r;
  logic signed [WHEEL_W-1:0] wheel_r [4];
  logic                out_valid_r;

  // accept and unit control
  logic in_acc, mul_go_b, step_go, tail_go, ud_go;
  logic u0_busy, u1_busy, u2_busy, u3_busy, ur_busy, ud_busy;
  logic divl_busy, diva_busy, divr_busy;
  logic signed [MA_W-1:0] u0_a, u1_a, u2_a, u3_a, ur_a;
  logic signed [MB_W-1:0] u0_b, u1_b, u2_b, u3_b, ur_b;
  logic signed [P_W-1:0]  p0, p1, p2, p3, pr;
  logic signed [PD_W-1:0] pd;
  logic [STEP_QW-1:0]     lstep, astep;
  logic [RAMP_W-1:0]      rq;
  logic signed [P_W-1:0]  rnum;

  assign in_acc   = in_ch.valid && (state_r == ST_IDLE);
  assign mul_go_b = (state_r == ST_PROD);
  assign step_go  = (state_r == ST_ANGLE) && !cord_busy_r && !u0_busy && !u1_busy;
  assign tail_go  = (state_r == ST_PROD_WAIT) && !u0_busy && !u1_busy && !u2_busy &&
                    !u3_busy && !ur_busy;
  assign ud_go    = tail_go && mode_r;

  // in idle the first two multipliers form accel * dt; later they rotate the ramps
  always_comb begin
    if (state_r == ST_IDLE) begin
      u0_a = MA_W'(lin_accel_r);
      u0_b = MB_W'(in_ch.elapsed_us);
      u1_a = MA_W'(ang_accel_r);
      u1_b = MB_W'(in_ch.elapsed_us);
    end else begin
      u0_a = ramp_vx_r;
      u0_b = cos_r;
      u1_a = ramp_vy_r;
      u1_b = sin_r;
    end
    u2_a = ramp_vy_r;
    u2_b = mode_r ? MB_W'(dash_gain_r) : cos_r;
    u3_a = ramp_vx_r;
    u3_b = sin_r;
    ur_a = ramp_wz_r;
    ur_b = MB_W'(lever_r);
  end

  mrk_smul #(.WA(MA_W), .WB(MB_W)) u_mul0 (
    .clk(clk), .rst_n(rst_n), .start(in_acc || mul_go_b), .a(u0_a), .b(u0_b),
    .busy(u0_busy), .p(p0));
  mrk_smul #(.WA(MA_W), .WB(MB_W)) u_mul1 (
    .clk(clk), .rst_n(rst_n), .start(in_acc || mul_go_b), .a(u1_a), .b(u1_b),
    .busy(u1_busy), .p(p1));
  mrk_smul #(.WA(MA_W), .WB(MB_W)) u_mul2 (
    .clk(clk), .rst_n(rst_n), .start(mul_go_b), .a(u2_a), .b(u2_b),
    .busy(u2_busy), .p(p2));
  mrk_smul #(.WA(MA_W), .WB(MB_W)) u_mul3 (
    .clk(clk), .rst_n(rst_n), .start(mul_go_b), .a(u3_a), .b(u3_b),
    .busy(u3_busy), .p(p3));
  mrk_smul #(.WA(MA_W), .WB(MB_W)) u_mulr (
    .clk(clk), .rst_n(rst_n), .start(mul_go_b), .a(ur_a), .b(ur_b),
    .busy(ur_busy), .p(pr));
  // dash: (vy * gain) * cos
  mrk_smul #(.WA(P_W), .WB(MB_W)) u_muld (
    .clk(clk), .rst_n(rst_n), .start(ud_go), .a(p2), .b(cos_r),
    .busy(ud_busy), .p(pd));

  mrk_udiv #(.WN(STEP_NW), .QW(STEP_QW), .DEN(STEP_DEN)) u_divl (
    .clk(clk), .rst_n(rst_n), .start(step_go),
    .num(STEP_NW'(p0[2*IN_W-1:0]) << F), .busy(divl_busy), .q(lstep));
  mrk_udiv #(.WN(STEP_NW), .QW(STEP_QW), .DEN(STEP_DEN)) u_diva (
    .clk(clk), .rst_n(rst_n), .start(step_go),
    .num(STEP_NW'(p1[2*IN_W-1:0]) << F), .busy(diva_busy), .q(astep));

  // floor division of a negative product: divide (|a| + den - 1) and negate
  assign rnum = pr[P_W-1] ? (-pr + P_W'(LEVER_DEN - 1)) : pr;

  mrk_udiv #(.WN(RN_W), .QW(RAMP_W), .DEN(LEVER_DEN)) u_divr (
    .clk(clk), .rst_n(rst_n), .start(tail_go), .num(rnum[RN_W-1:0]),
    .busy(divr_busy), .q(rq));

  function automatic logic signed [RAMP_W-1:0] ramp_step(
    input logic signed [RAMP_W-1:0] cur,
    input logic signed [IN_W-1:0]   tgt,
    input logic [STEP_QW-1:0]       step
  );
    logic signed [CMP_W-1:0] t;
    logic signed [CMP_W-1:0] c;
    logic signed [CMP_W-1:0] s;
    logic signed [CMP_W-1:0] n;
    t = CMP_W'(tgt) <<< F;
    c = CMP_W'(cur);
    s = CMP_W'(step);
    // a step may overshoot the target; the rule is kept as is
    if (t > c && t >= s) n = c + s;
    else if (t < c && t <= -s) n = c - s;
    else n = t;
    if (n > CMP_W'(RAMP_MAX)) return RAMP_MAX;
    if (n < CMP_W'(RAMP_MIN)) return RAMP_MIN;
    return RAMP_W'(n);
  endfunction

  // CORDIC datapath
  logic signed [CORD_W-1:0] cord_dx, cord_dy, cord_at, cos_rnd, sin_rnd;
  logic signed [CS_W-1:0]   cos_v, sin_v;
  logic [IN_W-1:0]          ang, ang_f;
  logic                     ang_flip;

  always_comb begin
    cord_dx = cord_y_r >>> cord_i_r;
    cord_dy = cord_x_r >>> cord_i_r;
    cord_at = CORD_W'(atan_lut(cord_i_r));
    cos_rnd = (cord_x_r + CORD_W'(CORD_ROUND)) >>> CORD_SHIFT;
    sin_rnd = (cord_y_r + CORD_W'(CORD_ROUND)) >>> CORD_SHIFT;
    cos_v   = flip_r ? -CS_W'(cos_rnd) : CS_W'(cos_rnd);
    sin_v   = flip_r ? -CS_W'(sin_rnd) : CS_W'(sin_rnd);
    // rotate by the negated yaw; fold the second and third quadrant by a half turn
    ang      = -in_ch.yaw_error;
    ang_flip = ang[IN_W-1] ^ ang[IN_W-2];
    ang_f    = ang_flip ? {~ang[IN_W-1], ang[IN_W-2:0]} : ang;
  end

  // combine products
  logic signed [PS_W-1:0] nsum_x, nsum_y;
  logic signed [DS_W-1:0] dsum;
  logic signed [CX_W-1:0] cx_nxt;
  logic signed [CY_W-1:0] cy_nxt;
  logic signed [R_W-1:0]  rot_nxt;

  always_comb begin
    nsum_x  = PS_W'(p0) + PS_W'(p1);
    nsum_y  = PS_W'(p2) - PS_W'(p3);
    dsum    = DS_W'(pd) + (DS_W'(p3) <<< GAIN_FRAC);
    cx_nxt  = mode_r ? '0 : CX_W'(nsum_x >>> CS_FRAC);
    cy_nxt  = mode_r ? CY_W'(dsum >>> (CS_FRAC + GAIN_FRAC)) : CY_W'(nsum_y >>> CS_FRAC);
    rot_nxt = pr[P_W-1] ? -signed'({1'b0, rq}) : signed'({1'b0, rq});
  end

  // wheel mix, round to mm/s, saturate
  logic signed [W_W-1:0]     cxw, cyw, rw;
  logic signed [W_W-1:0]     wmix [4];
  logic signed [W_W-1:0]     wrnd [4];
  logic signed [WHEEL_W-1:0] wheel_nxt [4];

  always_comb begin
    cxw = W_W'(cx_r);
    cyw = W_W'(cy_r);
    rw  = W_W'(rot_r);
    wmix[0] = -cyw - cxw - rw;
    wmix[1] =  cyw - cxw - rw;
    wmix[2] = -cyw + cxw - rw;
    wmix[3] =  cyw + cxw - rw;
    for (int k = 0; k < 4; k++) begin
      wrnd[k] = (wmix[k] + W_W'(HALF)) >>> F;
      if (wrnd[k] > W_W'(WHEEL_MAX)) wheel_nxt[k] = WHEEL_MAX;
      else if (wrnd[k] < W_W'(WHEEL_MIN)) wheel_nxt[k] = WHEEL_MIN;
      else wheel_nxt[k] = WHEEL_W'(wrnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lin_accel_r <= LIN_ACCEL_RST;
      ang_accel_r <= ANG_ACCEL_RST;
      lever_r     <= LEVER_RST;
      dash_gain_r <= DASH_GAIN_RST;
      ramp_vx_r   <= '0;
      ramp_vy_r   <= '0;
      ramp_wz_r   <= '0;
      cord_busy_r <= 1'b0;
      cord_i_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // unknown register indexes drop silently
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_LINEAR_ACCEL:  lin_accel_r <= cfg_ch.data;
          CFG_ANGULAR_ACCEL: ang_accel_r <= cfg_ch.data;
          CFG_LEVER_ARM:     lever_r     <= cfg_ch.data[LEVER_W-1:0];
          CFG_DASH_GAIN:     dash_gain_r <= cfg_ch.data;
          default: ;
        endcase
      end

      // the output state loads the register itself
      if (out_ch.ready && (state_r != ST_OUT)) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            tgt_vx_r    <= in_ch.target_vx;
            tgt_vy_r    <= in_ch.target_vy;
            tgt_wz_r    <= in_ch.target_wz;
            mode_r      <= in_ch.mode;
            flip_r      <= ang_flip;
            cord_x_r    <= CORDIC_GAIN;
            cord_y_r    <= '0;
            cord_z_r    <= CORD_W'({ang_f, 16'b0} >>> 0) - (ang_f[IN_W-1] ?
                           (CORD_W'(1) <<< (2 * IN_W)) : '0);
            cord_i_r    <= '0;
            cord_busy_r <= 1'b1;
            state_r     <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          if (cord_busy_r) begin
            if (!cord_z_r[CORD_W-1]) begin
              cord_x_r <= cord_x_r - cord_dx;
              cord_y_r <= cord_y_r + cord_dy;
              cord_z_r <= cord_z_r - cord_at;
            end else begin
              cord_x_r <= cord_x_r + cord_dx;
              cord_y_r <= cord_y_r - cord_dy;
              cord_z_r <= cord_z_r + cord_at;
            end
            if (cord_i_r == CORD_LAST) cord_busy_r <= 1'b0;
            else cord_i_r <= cord_i_r + CORD_IW'(1);
          end else if (!u0_busy && !u1_busy) begin
            cos_r   <= cos_v;
            sin_r   <= sin_v;
            state_r <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!divl_busy && !diva_busy) state_r <= ST_RAMP;
        end
        ST_RAMP: begin
          ramp_vx_r <= ramp_step(ramp_vx_r, tgt_vx_r, lstep);
          ramp_vy_r <= ramp_step(ramp_vy_r, tgt_vy_r, lstep);
          ramp_wz_r <= ramp_step(ramp_wz_r, tgt_wz_r, astep);
          state_r   <= ST_PROD;
        end
        ST_PROD: state_r <= ST_PROD_WAIT;
        ST_PROD_WAIT: begin
          if (tail_go) state_r <= ST_TAIL;
        end
        ST_TAIL: begin
          if (!ud_busy && !divr_busy) state_r <= ST_SUM;
        end
        ST_SUM: begin
          cx_r    <= cx_nxt;
          cy_r    <= cy_nxt;
          rot_r   <= rot_nxt;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            for (int k = 0; k < 4; k++) wheel_r[k] <= wheel_nxt[k];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ch.ready             = 1'b1;
  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.wheel_front_left  = wheel_r[0];
  assign out_ch.wheel_front_right = wheel_r[1];
  assign out_ch.wheel_rear_left   = wheel_r[2];
  assign out_ch.wheel_rear_right  = wheel_r[3];

endmodule

// ----- sv/mrk_chk.sv -----
module mrk_chk import mrk_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [WHEEL_W-1:0] wfl,
  input logic signed [WHEEL_W-1:0] wfr,
  input logic signed [WHEEL_W-1:0] wrl,
  input logic signed [WHEEL_W-1:0] wrr
);

  // one beat in flight: an accept closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after accept");

  // a new result only comes out of a working cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(wfl) && $stable(wfr) &&
                                $stable(wrl) && $stable(wrr))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mecanum_ramp_kinematics mrk_chk u_mrk_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .wfl(out_ch.wheel_front_left), .wfr(out_ch.wheel_front_right),
  .wrl(out_ch.wheel_rear_left), .wrr(out_ch.wheel_rear_right)
);
